### hw/rtl/pn3f_pkg.sv
// Shared types, constants, permutation table and gradient function for the fractal noise core.
package pn3f_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 16;
    localparam int TABLE_SIZE  = 256;

    localparam logic [31:0] UNIT_VAL = 32'(1) << FRAC_BITS;

    localparam logic [4:0]  OCT_RESET = 5'd4;
    localparam logic [15:0] LAC_RESET = 16'd8192;
    localparam logic [15:0] GAIN_RESET = 16'd2048;

    localparam logic [1:0] CFG_OCTAVES    = 2'd0;
    localparam logic [1:0] CFG_LACUNARITY = 2'd1;
    localparam logic [1:0] CFG_GAIN       = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POS_MUL,
        ST_POS_WB,
        ST_FADE_MUL,
        ST_FADE_WB,
        ST_HASH_A,
        ST_HASH_B,
        ST_HASH_C,
        ST_LERP_MUL,
        ST_LERP_WB,
        ST_ACC_MUL,
        ST_ACC_WB,
        ST_FREQ_MUL,
        ST_FREQ_WB,
        ST_AMP_MUL,
        ST_AMP_WB,
        ST_DIV_CHK,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam logic [7:0] PERM_TABLE [0:TABLE_SIZE-1] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] f_perm(input logic [7:0] idx);
        return PERM_TABLE[idx];
    endfunction

    function automatic logic signed [18:0] f_grad(input logic [7:0] hv,
                                                  input logic signed [17:0] x,
                                                  input logic signed [17:0] y,
                                                  input logic signed [17:0] z);
        logic [3:0] h;
        logic signed [18:0] a;
        logic signed [18:0] b;
        h = hv[3:0];
        a = (h < 4'd8) ? 19'(x) : 19'(y);
        if (h < 4'd4) begin
            b = 19'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            b = 19'(x);
        end else begin
            b = 19'(z);
        end
        return (h[0] ? -a : a) + (h[1] ? -b : b);
    endfunction

endpackage

### hw/rtl/perlin_noise_3d_fractal_core.sv
// Fractal 3D improved Perlin noise core built around one shared multiplier.
// Each octave takes 22 passes through the shared 33 x 33 multiplier, each a multiply and a write-back state,
// plus three permutation lookup steps (hash A, B and C).
// The final divide is a restoring divider at one quotient bit per cycle.
// One item is in flight at a time; a new input is taken only once the core has returned to idle.
// Synchronous active-low reset returns the sequencer to idle and loads default registers.
module perlin_noise_3d_fractal_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    pn3f_pkg::t_state r_state;
    pn3f_pkg::t_state n_state;

    logic [4:0]  r_octaves;
    logic [15:0] r_lacunarity;
    logic [15:0] r_gain;

    logic signed [31:0] r_pos [3];
    logic [7:0]  r_cell [3];
    logic [15:0] r_frac [3];
    logic [16:0] r_fade [3];
    logic signed [18:0] r_val [8];
    logic [15:0] r_t2;
    logic [15:0] r_t3;
    logic [8:0]  r_ha, r_hb, r_haa, r_hab, r_hba, r_hbb;
    logic [1:0]  r_axis;
    logic [1:0]  r_fstep;
    logic [2:0]  r_lstep;
    logic [4:0]  r_oct;
    logic [4:0]  r_noct;
    logic [4:0]  r_dstep;
    logic [31:0] r_freq;
    logic [31:0] r_amp;
    logic [36:0] r_norm;
    logic signed [63:0] r_total;
    logic signed [65:0] r_prod;
    logic [63:0] r_rem;
    logic [52:0] r_dsor;
    logic [16:0] r_quo;
    logic        r_neg;
    logic        r_sat;
    logic        r_ovalid;
    logic signed [15:0] r_out;

    logic signed [32:0] c_mul_a;
    logic signed [32:0] c_mul_b;
    logic signed [65:0] c_mul_p;
    logic [15:0] c_t;
    logic [22:0] c_inner;
    logic [21:0] c_inner_pos;
    logic signed [18:0] c_la;
    logic signed [18:0] c_lb;
    logic [16:0] c_lt;
    logic signed [19:0] c_ldiff;
    logic signed [18:0] c_lres;
    logic [49:0] c_fade_full;
    logic [35:0] c_scaled;
    logic [63:0] c_mag;
    logic [4:0]  c_nsel;
    logic signed [17:0] c_q;
    logic signed [16:0] c_r;
    logic signed [15:0] c_result;
    logic signed [17:0] c_x0, c_x1, c_y0, c_y1, c_z0, c_z1;

    assign o_ready       = (r_state == pn3f_pkg::ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_noise_value = r_out;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves    <= pn3f_pkg::OCT_RESET;
            r_lacunarity <= pn3f_pkg::LAC_RESET;
            r_gain       <= pn3f_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pn3f_pkg::CFG_OCTAVES:    r_octaves <= i_cfg_data[4:0];
                pn3f_pkg::CFG_LACUNARITY: r_lacunarity <= i_cfg_data;
                pn3f_pkg::CFG_GAIN:       r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_octaves == 5'd0) begin
            c_nsel = 5'd1;
        end else if (r_octaves > 5'(pn3f_pkg::MAX_OCTAVES)) begin
            c_nsel = 5'(pn3f_pkg::MAX_OCTAVES);
        end else begin
            c_nsel = r_octaves;
        end
    end

    assign c_t = r_frac[r_axis];
    assign c_inner = 23'd655360 + ({7'd0, r_t2} * 23'd6) - ({7'd0, c_t} * 23'd15);
    assign c_inner_pos = c_inner[22] ? 22'd0 : c_inner[21:0];
    assign c_fade_full = r_prod[65:16];
    assign c_scaled = r_prod[47:12];

    always_comb begin
        case (r_lstep)
            3'd0: begin c_la = r_val[0]; c_lb = r_val[1]; c_lt = r_fade[0]; end
            3'd1: begin c_la = r_val[2]; c_lb = r_val[3]; c_lt = r_fade[0]; end
            3'd2: begin c_la = r_val[0]; c_lb = r_val[2]; c_lt = r_fade[1]; end
            3'd3: begin c_la = r_val[4]; c_lb = r_val[5]; c_lt = r_fade[0]; end
            3'd4: begin c_la = r_val[6]; c_lb = r_val[7]; c_lt = r_fade[0]; end
            3'd5: begin c_la = r_val[4]; c_lb = r_val[6]; c_lt = r_fade[1]; end
            3'd6: begin c_la = r_val[0]; c_lb = r_val[4]; c_lt = r_fade[2]; end
            default: begin c_la = r_val[0]; c_lb = r_val[1]; c_lt = r_fade[0]; end
        endcase
    end

    assign c_ldiff = 20'(c_lb) - 20'(c_la);
    assign c_lres  = c_la + r_prod[34:16];

    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        case (r_state)
            pn3f_pkg::ST_POS_MUL: begin
                c_mul_a = 33'(r_pos[r_axis]);
                c_mul_b = $signed({1'b0, r_freq});
            end
            pn3f_pkg::ST_FADE_MUL: begin
                case (r_fstep)
                    2'd0: begin
                        c_mul_a = $signed({17'd0, c_t});
                        c_mul_b = $signed({17'd0, c_t});
                    end
                    2'd1: begin
                        c_mul_a = $signed({17'd0, r_t2});
                        c_mul_b = $signed({17'd0, c_t});
                    end
                    default: begin
                        c_mul_a = $signed({17'd0, r_t3});
                        c_mul_b = $signed({11'd0, c_inner_pos});
                    end
                endcase
            end
            pn3f_pkg::ST_LERP_MUL: begin
                c_mul_a = 33'(c_ldiff);
                c_mul_b = $signed({16'd0, c_lt});
            end
            pn3f_pkg::ST_ACC_MUL: begin
                c_mul_a = 33'(r_val[0]);
                c_mul_b = $signed({1'b0, r_amp});
            end
            pn3f_pkg::ST_FREQ_MUL: begin
                c_mul_a = $signed({1'b0, r_freq});
                c_mul_b = $signed({17'd0, r_lacunarity});
            end
            pn3f_pkg::ST_AMP_MUL: begin
                c_mul_a = $signed({1'b0, r_amp});
                c_mul_b = $signed({17'd0, r_gain});
            end
            default: ;
        endcase
    end

    assign c_mul_p = c_mul_a * c_mul_b;

    assign c_x0 = $signed({2'b00, r_frac[0]});
    assign c_x1 = $signed({2'b11, r_frac[0]});
    assign c_y0 = $signed({2'b00, r_frac[1]});
    assign c_y1 = $signed({2'b11, r_frac[1]});
    assign c_z0 = $signed({2'b00, r_frac[2]});
    assign c_z1 = $signed({2'b11, r_frac[2]});

    assign c_mag = r_total[63] ? 64'(-r_total) : 64'(r_total);

    always_comb begin
        c_q = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        c_r = 17'(c_q >>> 1);
        if (r_sat) begin
            c_result = r_neg ? -16'sd32768 : 16'sd32767;
        end else if (c_r > 17'sd32767) begin
            c_result = 16'sd32767;
        end else if (c_r < -17'sd32768) begin
            c_result = -16'sd32768;
        end else begin
            c_result = 16'(c_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pn3f_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pn3f_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pn3f_pkg::ST_POS_MUL;
                end
            end
            pn3f_pkg::ST_POS_MUL: n_state = pn3f_pkg::ST_POS_WB;
            pn3f_pkg::ST_POS_WB: begin
                n_state = (r_axis == 2'd2) ? pn3f_pkg::ST_FADE_MUL : pn3f_pkg::ST_POS_MUL;
            end
            pn3f_pkg::ST_FADE_MUL: n_state = pn3f_pkg::ST_FADE_WB;
            pn3f_pkg::ST_FADE_WB: begin
                if (r_fstep == 2'd2 && r_axis == 2'd2) begin
                    n_state = pn3f_pkg::ST_HASH_A;
                end else begin
                    n_state = pn3f_pkg::ST_FADE_MUL;
                end
            end
            pn3f_pkg::ST_HASH_A: n_state = pn3f_pkg::ST_HASH_B;
            pn3f_pkg::ST_HASH_B: n_state = pn3f_pkg::ST_HASH_C;
            pn3f_pkg::ST_HASH_C: n_state = pn3f_pkg::ST_LERP_MUL;
            pn3f_pkg::ST_LERP_MUL: n_state = pn3f_pkg::ST_LERP_WB;
            pn3f_pkg::ST_LERP_WB: begin
                n_state = (r_lstep == 3'd6) ? pn3f_pkg::ST_ACC_MUL : pn3f_pkg::ST_LERP_MUL;
            end
            pn3f_pkg::ST_ACC_MUL: n_state = pn3f_pkg::ST_ACC_WB;
            pn3f_pkg::ST_ACC_WB: n_state = pn3f_pkg::ST_FREQ_MUL;
            pn3f_pkg::ST_FREQ_MUL: n_state = pn3f_pkg::ST_FREQ_WB;
            pn3f_pkg::ST_FREQ_WB: n_state = pn3f_pkg::ST_AMP_MUL;
            pn3f_pkg::ST_AMP_MUL: n_state = pn3f_pkg::ST_AMP_WB;
            pn3f_pkg::ST_AMP_WB: begin
                if (r_oct == r_noct - 5'd1) begin
                    n_state = pn3f_pkg::ST_DIV_CHK;
                end else begin
                    n_state = pn3f_pkg::ST_POS_MUL;
                end
            end
            pn3f_pkg::ST_DIV_CHK: n_state = pn3f_pkg::ST_DIV;
            pn3f_pkg::ST_DIV: begin
                n_state = (r_dstep == 5'd16) ? pn3f_pkg::ST_DONE : pn3f_pkg::ST_DIV;
            end
            pn3f_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = pn3f_pkg::ST_IDLE;
                end
            end
            default: n_state = pn3f_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pn3f_pkg::ST_DONE && (!r_ovalid || i_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= c_mul_p;
        case (r_state)
            pn3f_pkg::ST_IDLE: begin
                if (i_valid) begin
                    r_pos[0] <= i_pos_x;
                    r_pos[1] <= i_pos_y;
                    r_pos[2] <= i_pos_z;
                    r_freq   <= pn3f_pkg::UNIT_VAL;
                    r_amp    <= pn3f_pkg::UNIT_VAL;
                    r_norm   <= '0;
                    r_total  <= '0;
                    r_oct    <= '0;
                    r_noct   <= c_nsel;
                    r_axis   <= '0;
                end
            end
            pn3f_pkg::ST_POS_WB: begin
                r_cell[r_axis] <= r_prod[39:32];
                r_frac[r_axis] <= r_prod[31:16];
                r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                r_fstep <= '0;
            end
            pn3f_pkg::ST_FADE_WB: begin
                case (r_fstep)
                    2'd0: r_t2 <= r_prod[31:16];
                    2'd1: r_t3 <= r_prod[31:16];
                    default: begin
                        if (c_fade_full > 50'd65536) begin
                            r_fade[r_axis] <= 17'd65536;
                        end else begin
                            r_fade[r_axis] <= c_fade_full[16:0];
                        end
                    end
                endcase
                if (r_fstep == 2'd2) begin
                    r_fstep <= '0;
                    r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end else begin
                    r_fstep <= r_fstep + 2'd1;
                end
            end
            pn3f_pkg::ST_HASH_A: begin
                r_ha <= {1'b0, pn3f_pkg::f_perm(r_cell[0])} + {1'b0, r_cell[1]};
                r_hb <= {1'b0, pn3f_pkg::f_perm(r_cell[0] + 8'd1)} + {1'b0, r_cell[1]};
            end
            pn3f_pkg::ST_HASH_B: begin
                r_haa <= {1'b0, pn3f_pkg::f_perm(r_ha[7:0])} + {1'b0, r_cell[2]};
                r_hab <= {1'b0, pn3f_pkg::f_perm(r_ha[7:0] + 8'd1)} + {1'b0, r_cell[2]};
                r_hba <= {1'b0, pn3f_pkg::f_perm(r_hb[7:0])} + {1'b0, r_cell[2]};
                r_hbb <= {1'b0, pn3f_pkg::f_perm(r_hb[7:0] + 8'd1)} + {1'b0, r_cell[2]};
            end
            pn3f_pkg::ST_HASH_C: begin
                r_val[0] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_haa[7:0]), c_x0, c_y0, c_z0);
                r_val[1] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hba[7:0]), c_x1, c_y0, c_z0);
                r_val[2] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hab[7:0]), c_x0, c_y1, c_z0);
                r_val[3] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hbb[7:0]), c_x1, c_y1, c_z0);
                r_val[4] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_haa[7:0] + 8'd1),
                                             c_x0, c_y0, c_z1);
                r_val[5] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hba[7:0] + 8'd1),
                                             c_x1, c_y0, c_z1);
                r_val[6] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hab[7:0] + 8'd1),
                                             c_x0, c_y1, c_z1);
                r_val[7] <= pn3f_pkg::f_grad(pn3f_pkg::f_perm(r_hbb[7:0] + 8'd1),
                                             c_x1, c_y1, c_z1);
                r_lstep  <= '0;
            end
            pn3f_pkg::ST_LERP_WB: begin
                case (r_lstep)
                    3'd1: r_val[2] <= c_lres;
                    3'd3: r_val[4] <= c_lres;
                    3'd4: r_val[6] <= c_lres;
                    3'd5: r_val[4] <= c_lres;
                    default: r_val[0] <= c_lres;
                endcase
                r_lstep <= r_lstep + 3'd1;
            end
            pn3f_pkg::ST_ACC_WB: begin
                r_total <= r_total + r_prod[63:0];
                r_norm  <= r_norm + {5'd0, r_amp};
            end
            pn3f_pkg::ST_FREQ_WB: begin
                r_freq <= (|c_scaled[35:32]) ? 32'hFFFF_FFFF : c_scaled[31:0];
            end
            pn3f_pkg::ST_AMP_WB: begin
                r_amp  <= (|c_scaled[35:32]) ? 32'hFFFF_FFFF : c_scaled[31:0];
                r_oct  <= r_oct + 5'd1;
                r_axis <= '0;
            end
            pn3f_pkg::ST_DIV_CHK: begin
                r_rem   <= c_mag;
                r_neg   <= r_total[63];
                r_sat   <= (c_mag >= {10'd0, r_norm, 17'd0});
                r_dsor  <= {r_norm, 16'd0};
                r_quo   <= '0;
                r_dstep <= '0;
            end
            pn3f_pkg::ST_DIV: begin
                if (r_rem >= {11'd0, r_dsor}) begin
                    r_rem <= r_rem - {11'd0, r_dsor};
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_dsor  <= r_dsor >> 1;
                r_dstep <= r_dstep + 5'd1;
            end
            pn3f_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    r_out <= c_result;
                end
            end
            default: ;
        endcase
    end

endmodule
